@@ hdl/dlp_pkg.sv @@
// Shared types, codes and constants for the decimal list parser.
`timescale 1ns / 1ps
`default_nettype none
package dlp_pkg;

	// Field widths
	localparam int NUM_W   = 30;
	localparam int CNT_W   = 16;
	localparam int KIND_W  = 2;
	localparam int CODE_W  = 3;
	localparam int DC_W    = 4;
	localparam int PROD_W  = 34;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_VALUE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

	// Error codes
	localparam logic [CODE_W-1:0] ERR_NONE    = 3'd0;
	localparam logic [CODE_W-1:0] ERR_ILLEGAL = 3'd1;
	localparam logic [CODE_W-1:0] ERR_RANGE   = 3'd2;
	localparam logic [CODE_W-1:0] ERR_DIGITS  = 3'd3;
	localparam logic [CODE_W-1:0] ERR_COUNT   = 3'd4;

	// Character codes
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [DC_W-1:0] MAX_DIGITS = 4'd9;

	// Register reset values and indexes
	localparam logic [NUM_W-1:0] MIN_RESET   = 30'd0;
	localparam logic [NUM_W-1:0] MAX_RESET   = 30'd999999999;
	localparam logic [CNT_W-1:0] COUNT_RESET = 16'd65535;
	localparam logic [1:0] REG_MIN   = 2'd0;
	localparam logic [1:0] REG_MAX   = 2'd1;
	localparam logic [1:0] REG_COUNT = 2'd2;

	// Result queue
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = 2;
	localparam int FCNT_W     = 3;

	typedef struct packed {
		logic [NUM_W-1:0] min_value;
		logic [NUM_W-1:0] max_value;
		logic [CNT_W-1:0] max_count;
	} cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [NUM_W-1:0]  number;
		logic [CODE_W-1:0] error_code;
		logic [CNT_W-1:0]  value_index;
		logic              last_of_run;
	} result_t;

	// Up to two results per input word, r0 first
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

	function automatic result_t mk_result(input logic [KIND_W-1:0] kind,
		input logic [NUM_W-1:0] number, input logic [CODE_W-1:0] code,
		input logic [CNT_W-1:0] index);
		result_t r;
		r.kind        = kind;
		r.number      = number;
		r.error_code  = code;
		r.value_index = index;
		r.last_of_run = 1'b0;
		return r;
	endfunction

endpackage
`default_nettype wire

@@ hdl/decimal_list_parser_with_limits.sv @@
// Top level of the decimal list parser: config registers, parser, result queue.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  in      | input     | in_valid/in_ready  | text_byte, end_of_input
//  out     | output    | out_valid/out_ready| kind, number, error_code, value_index,
//          |           |                    | last_of_run
//  apb     | input     | psel/penable/pready| paddr, pwrite, pwdata, prdata
//
// One input word per cycle while in_ready is high; each word is parsed in the cycle it is accepted.
// Results enter a four-entry queue and leave one per cycle while out_ready is high, so a word
// that yields two results (end of input after a valid pending number) fills two queue entries.
// in_ready drops only while the queue holds more than two results.
// Reset clears parse state, queue and registers; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module decimal_list_parser_with_limits (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  text_byte,
	input  wire logic        end_of_input,
	// result stream
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [29:0]      number,
	output logic [2:0]       error_code,
	output logic [15:0]      value_index,
	output logic             last_of_run,
	// config port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	dlp_pkg::cfg_t     cfg_q;
	dlp_pkg::push_t    push;
	dlp_pkg::result_t  head;
	logic              fire, room, cfg_wr;
	logic [1:0]        reg_idx;

	assign pready   = 1'b1;
	assign reg_idx  = paddr[3:2];
	assign cfg_wr   = psel && penable && pwrite;
	assign in_ready = room;
	assign fire     = in_valid && room;

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_value <= dlp_pkg::MIN_RESET;
			cfg_q.max_value <= dlp_pkg::MAX_RESET;
			cfg_q.max_count <= dlp_pkg::COUNT_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				dlp_pkg::REG_MIN:   cfg_q.min_value <= pwdata[29:0];
				dlp_pkg::REG_MAX:   cfg_q.max_value <= pwdata[29:0];
				dlp_pkg::REG_COUNT: cfg_q.max_count <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Readback
	always_comb begin
		case (reg_idx)
			dlp_pkg::REG_MIN:   prdata = {2'b0, cfg_q.min_value};
			dlp_pkg::REG_MAX:   prdata = {2'b0, cfg_q.max_value};
			dlp_pkg::REG_COUNT: prdata = {16'b0, cfg_q.max_count};
			default:            prdata = '0;
		endcase
	end

	dlp_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.text_byte    (text_byte),
		.end_of_input (end_of_input),
		.cfg          (cfg_q),
		.push         (push)
	);

	dlp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign kind        = head.kind;
	assign number      = head.number;
	assign error_code  = head.error_code;
	assign value_index = head.value_index;
	assign last_of_run = head.last_of_run;

endmodule
`default_nettype wire

@@ hdl/dlp_core.sv @@
// Parse state and per-byte result logic of the decimal list parser.
`timescale 1ns / 1ps
`default_nettype none
module dlp_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         fire,
	input  wire logic [7:0]                   text_byte,
	input  wire logic                         end_of_input,
	input  wire dlp_pkg::cfg_t                cfg,
	output dlp_pkg::push_t                    push
);

	logic [dlp_pkg::NUM_W-1:0]  acc_q, acc_d;
	logic [dlp_pkg::DC_W-1:0]   dc_q, dc_d;
	logic [dlp_pkg::CNT_W-1:0]  vs_q, vs_d;
	logic                       err_q, err_d;

	logic                        pending, below_min, full, fin_err, is_sep, is_digit;
	logic [dlp_pkg::CNT_W-1:0]   vs_inc, vs_after;
	logic [dlp_pkg::CODE_W-1:0]  fin_code;
	logic [3:0]                  digit;
	logic [dlp_pkg::PROD_W-1:0]  acc_w, prod;
	dlp_pkg::result_t            fin_res;

	// Finishing the pending number
	assign pending   = dc_q != '0;
	assign below_min = acc_q < cfg.min_value;
	assign full      = vs_q >= cfg.max_count;
	assign fin_err   = pending && (below_min || full);
	assign fin_code  = below_min ? dlp_pkg::ERR_RANGE : dlp_pkg::ERR_COUNT;
	assign vs_inc    = vs_q + 16'd1;
	assign vs_after  = (pending && !fin_err) ? vs_inc : vs_q;
	assign fin_res   = fin_err
		? dlp_pkg::mk_result(dlp_pkg::KIND_ERROR, '0, fin_code, vs_q)
		: dlp_pkg::mk_result(dlp_pkg::KIND_VALUE, acc_q, dlp_pkg::ERR_NONE, vs_inc);

	// Byte classes and next accumulator (x10 as two shifts)
	assign is_sep   = (text_byte == dlp_pkg::CH_COMMA) || (text_byte == dlp_pkg::CH_SPACE)
		|| (text_byte == dlp_pkg::CH_LF) || (text_byte == dlp_pkg::CH_CR);
	assign is_digit = (text_byte >= dlp_pkg::CH_ZERO) && (text_byte <= dlp_pkg::CH_NINE);
	assign digit    = text_byte[3:0];
	assign acc_w    = {4'b0, acc_q};
	assign prod     = (acc_w << 3) + (acc_w << 1) + {30'b0, digit};

	// Next state and results
	always_comb begin
		acc_d = acc_q;
		dc_d  = dc_q;
		vs_d  = vs_q;
		err_d = err_q;
		push  = '0;
		if (fire) begin
			if (end_of_input) begin
				if (!err_q) begin
					if (pending && fin_err) begin
						push.r0 = fin_res;
						push.n  = 2'd1;
					end else if (pending) begin
						push.r0 = fin_res;
						push.r1 = dlp_pkg::mk_result(dlp_pkg::KIND_DONE, '0,
							dlp_pkg::ERR_NONE, vs_after);
						push.n  = 2'd2;
					end else begin
						push.r0 = dlp_pkg::mk_result(dlp_pkg::KIND_DONE, '0,
							dlp_pkg::ERR_NONE, vs_q);
						push.n  = 2'd1;
					end
				end
				acc_d = '0;
				dc_d  = '0;
				vs_d  = '0;
				err_d = 1'b0;
			end else if (!err_q) begin
				if (is_sep) begin
					acc_d = '0;
					dc_d  = '0;
					vs_d  = vs_after;
					err_d = fin_err;
					if (pending) begin
						push.r0 = fin_res;
						push.n  = 2'd1;
					end
				end else if (!is_digit) begin
					push.r0 = dlp_pkg::mk_result(dlp_pkg::KIND_ERROR, '0,
						dlp_pkg::ERR_ILLEGAL, vs_q);
					push.n  = 2'd1;
					err_d   = 1'b1;
				end else if (dc_q >= dlp_pkg::MAX_DIGITS) begin
					push.r0 = dlp_pkg::mk_result(dlp_pkg::KIND_ERROR, '0,
						dlp_pkg::ERR_DIGITS, vs_q);
					push.n  = 2'd1;
					err_d   = 1'b1;
				end else begin
					acc_d = prod[dlp_pkg::NUM_W-1:0];
					dc_d  = dc_q + 4'd1;
					if (prod > {4'b0, cfg.max_value}) begin
						push.r0 = dlp_pkg::mk_result(dlp_pkg::KIND_ERROR, '0,
							dlp_pkg::ERR_RANGE, vs_q);
						push.n  = 2'd1;
						err_d   = 1'b1;
					end
				end
			end
		end
		// flag the final result of this word
		if (push.n == 2'd1) push.r0.last_of_run = 1'b1;
		if (push.n == 2'd2) push.r1.last_of_run = 1'b1;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			dc_q  <= '0;
			vs_q  <= '0;
			err_q <= 1'b0;
		end else begin
			acc_q <= acc_d;
			dc_q  <= dc_d;
			vs_q  <= vs_d;
			err_q <= err_d;
		end
	end

endmodule
`default_nettype wire

@@ hdl/dlp_fifo.sv @@
// Four-entry result queue: up to two writes and one read per cycle.
`timescale 1ns / 1ps
`default_nettype none
module dlp_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire dlp_pkg::push_t   push,
	output logic                  room,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output dlp_pkg::result_t      head
);

	dlp_pkg::result_t             mem_q [dlp_pkg::FIFO_DEPTH];
	logic [dlp_pkg::PTR_W-1:0]    wr_ptr_q, rd_ptr_q, wr_ptr1;
	logic [dlp_pkg::FCNT_W-1:0]   count_q;
	logic                         pop;

	assign out_valid = count_q != '0;
	assign pop       = out_valid && out_ready;
	assign room      = count_q <= dlp_pkg::FCNT_W'(dlp_pkg::FIFO_DEPTH - 2);
	assign head      = mem_q[rd_ptr_q];
	assign wr_ptr1   = wr_ptr_q + 2'd1;

	// Storage
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) mem_q[wr_ptr_q] <= push.r0;
		if (push.n == 2'd2) mem_q[wr_ptr1] <= push.r1;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push.n;
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			count_q  <= count_q + {1'b0, push.n} - {2'b0, pop};
		end
	end

endmodule
`default_nettype wire

@@ hdl/dlp_checker.sv @@
// Port-level checks on the parser's result stream, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module dlp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  kind,
	input wire logic [29:0] number,
	input wire logic [2:0]  error_code,
	input wire logic        last_of_run
);

	// A value word carries no error code
	a_value_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == dlp_pkg::KIND_VALUE |-> error_code == dlp_pkg::ERR_NONE)
		else $error("value word with error code");

	// Only value words carry a number
	a_number_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != dlp_pkg::KIND_VALUE |-> number == '0)
		else $error("nonzero number on non-value word");

	// Done is always the last word of its input word, without code
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == dlp_pkg::KIND_DONE |-> last_of_run && error_code == '0)
		else $error("done word not last or with code");

	// An error word names its error
	a_error_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == dlp_pkg::KIND_ERROR |-> error_code != dlp_pkg::ERR_NONE)
		else $error("error word without code");

	// Stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(number))
		else $error("stalled word changed");

endmodule

bind decimal_list_parser_with_limits dlp_checker u_dlp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.kind        (kind),
	.number      (number),
	.error_code  (error_code),
	.last_of_run (last_of_run)
);
`default_nettype wire
